/* rtl/lsf_pkg.sv */
package lsf_pkg;

    // fixed field widths of the header and result transactions
    localparam int PORT_W    = 3;
    localparam int IN_ADDR_W = 16;
    localparam int MASK_W    = 8;

    // defaults for the top-level parameters
    localparam int DEF_NUM_PORTS     = 8;
    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_ADDR_BITS     = 16;

    // header transaction
    typedef struct packed {
        logic [PORT_W-1:0]    in_port;
        logic [IN_ADDR_W-1:0] src_addr;
        logic [IN_ADDR_W-1:0] dst_addr;
    } lsf_in_t;

    // result transaction
    typedef struct packed {
        logic [MASK_W-1:0] port_mask;
        logic              flooded;
        logic              table_full;
    } lsf_out_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              src_hit;
        logic              dst_hit;
        logic [PORT_W-1:0] dst_port;
    } lsf_token_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } lsf_state_t;

endpackage

/* rtl/learning_switch_forwarder_top.sv */
// Station-learning forwarder for a small packet switch.
// Input channel s_*: one header transaction (in_port, src_addr, dst_addr).
// Result channel m_*: one transaction per header (port_mask, flooded,
// table_full), in header order.
// Each header first learns its source (port refresh, append, or table_full
// when no room is left), then looks up its destination; a miss floods to
// every existing port except the arrival port.
// The table is a row of TABLE_ENTRIES cells; a search token walks the row
// one cell per cycle, is captured at the end of the row, and the result is
// then loaded into the output register. One header is in work at a time;
// s_ready is high while the controller is idle, so the next header is
// accepted only once the previous result has been loaded.
// The result sits in an output register; a new header is accepted while it
// waits. If the receiver stalls, a finished search holds before the append
// until the output register is free.
// Reset empties the table (fill count to zero) at once, with no clearing
// pass; entry contents are only read below the fill count.
module learning_switch_forwarder_top
    import lsf_pkg::*;
#(
    parameter int NUM_PORTS     = DEF_NUM_PORTS,
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int ADDR_BITS     = DEF_ADDR_BITS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lsf_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output lsf_out_t m_data
);

    localparam int KEY_W = (ADDR_BITS < IN_ADDR_W) ? ADDR_BITS : IN_ADDR_W;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    lsf_state_t        state_reg;
    lsf_state_t        state_next;
    logic              launch_reg;
    logic [PORT_W-1:0] port_reg;
    logic [KEY_W-1:0]  src_reg;
    logic [KEY_W-1:0]  dst_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    lsf_token_t        fin_reg;
    logic              m_valid_reg;
    lsf_out_t          m_data_reg;
    lsf_out_t          m_data_next;

    lsf_token_t        tok [0:TABLE_ENTRIES];
    lsf_token_t        tok_last;
    logic              accept;
    logic              out_free;
    logic              capture_en;
    logic              finish_en;
    logic              append_en;
    logic              full;
    logic              same_addr;
    logic              dst_hit;
    logic [PORT_W-1:0] hit_port;
    logic [MASK_W-1:0] exist_mask;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign tok_last = tok[TABLE_ENTRIES];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (tok_last.valid) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        s_ready    = 1'b0;
        capture_en = 1'b0;
        finish_en  = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready    = 1'b1;
            ST_SEARCH: capture_en = tok_last.valid;
            ST_FINISH: finish_en  = out_free;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= accept;
        end
    end

    // header registers, broadcast to every cell
    always_ff @(posedge aclk) begin
        if (accept) begin
            port_reg <= s_data.in_port;
            src_reg  <= s_data.src_addr[KEY_W-1:0];
            dst_reg  <= s_data.dst_addr[KEY_W-1:0];
        end
    end

    // cell row
    assign tok[0] = '{valid: launch_reg, src_hit: 1'b0, dst_hit: 1'b0, dst_port: '0};

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        lsf_cell #(
            .KEY_W (KEY_W),
            .CNT_W (CNT_W),
            .INDEX (k)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .tok_in      (tok[k]),
            .src_key     (src_reg),
            .dst_key     (dst_reg),
            .in_port     (port_reg),
            .entry_count (count_reg),
            .append_en   (append_en),
            .tok_out     (tok[k+1])
        );
    end

    // token at the end of the row
    always_ff @(posedge aclk) begin
        if (capture_en) begin
            fin_reg <= tok_last;
        end
    end

    // learning decision
    assign full      = count_reg == CNT_W'(TABLE_ENTRIES);
    assign append_en = finish_en && !fin_reg.src_hit && !full;

    always_comb begin
        count_next = count_reg;
        if (append_en) count_next = count_reg + CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // forwarding mask; a destination equal to the source sees the fresh entry
    always_comb begin
        for (int p = 0; p < MASK_W; p++) begin
            exist_mask[p] = p < NUM_PORTS;
        end
        same_addr = dst_reg == src_reg;
        dst_hit   = fin_reg.dst_hit || (same_addr && (fin_reg.src_hit || !full));
        hit_port  = same_addr ? port_reg : fin_reg.dst_port;
        m_data_next.table_full = !fin_reg.src_hit && full;
        m_data_next.flooded    = !dst_hit;
        if (dst_hit) begin
            m_data_next.port_mask = (MASK_W'(1) << hit_port) & exist_mask;
        end else begin
            m_data_next.port_mask = exist_mask & ~(MASK_W'(1) << port_reg);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish_en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a token leaves the row only while a search is running
    a_token_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_last.valid |-> state_reg == ST_SEARCH)
        else $error("search token outside search state");

    // fill count never passes the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    // an accepted header starts a search on the next cycle
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_SEARCH) && launch_reg)
        else $error("accepted header did not launch a search");

    // a forwarded (not flooded) result names at most one port
    a_hit_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.flooded) |-> $onehot0(m_data.port_mask))
        else $error("hit result with several ports");

    // table_full only reported once the table is full
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.table_full) |-> full)
        else $error("table_full with room left");

endmodule

/* rtl/lsf_cell.sv */
module lsf_cell
    import lsf_pkg::*;
#(
    parameter int KEY_W = 16,
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lsf_token_t        tok_in,
    input  logic [KEY_W-1:0]  src_key,
    input  logic [KEY_W-1:0]  dst_key,
    input  logic [PORT_W-1:0] in_port,
    input  logic [CNT_W-1:0]  entry_count,
    input  logic              append_en,
    output lsf_token_t        tok_out
);

    logic [KEY_W-1:0]  addr_reg;
    logic [PORT_W-1:0] port_reg;
    lsf_token_t        tok_out_reg;
    lsf_token_t        tok_out_next;
    logic              entry_valid;
    logic              is_tail;
    logic              src_match;
    logic              dst_match;

    // this cell holds a live entry when its index is below the fill count
    assign entry_valid = CNT_W'(INDEX) < entry_count;
    assign is_tail     = CNT_W'(INDEX) == entry_count;
    assign src_match   = tok_in.valid && entry_valid && (addr_reg == src_key);
    assign dst_match   = tok_in.valid && entry_valid && (addr_reg == dst_key);

    // fold this cell's compare results into the passing token
    always_comb begin
        tok_out_next          = tok_in;
        tok_out_next.src_hit  = tok_in.src_hit | src_match;
        tok_out_next.dst_hit  = tok_in.dst_hit | dst_match;
        tok_out_next.dst_port = dst_match ? port_reg : tok_in.dst_port;
    end

    // token stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_out_reg <= '0;
        end else begin
            tok_out_reg <= tok_out_next;
        end
    end

    // entry storage: port refresh on a source hit, fill on append
    always_ff @(posedge aclk) begin
        if (src_match) begin
            port_reg <= in_port;
        end else if (append_en && is_tail) begin
            addr_reg <= src_key;
            port_reg <= in_port;
        end
    end

    assign tok_out = tok_out_reg;

endmodule
